// ===== src/assert_macros.svh =====
// Assertion shorthands for the timestamp parser.
// Used by modules that check their own invariants; needs clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define TSMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen on a clock edge outside reset.
`define TSMP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/tsmp_pkg.sv =====
// Shared types and constants of the timestamp parser.
// Used by every module of the block; depends on nothing.
package tsmp_pkg;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic [26:0] now_millis;
    logic [31:0] today;
  } item_t;

  typedef struct packed {
    logic        ok;
    logic [26:0] millis_of_day;
    logic [31:0] day_number;
  } result_t;

  typedef struct packed {
    logic        ok;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  fraction;
    logic [26:0] now_millis;
    logic [31:0] today;
  } job_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [6:0] MAX_HOURS    = 7'd23;
  localparam logic [6:0] MAX_MINSEC   = 7'd59;
  localparam logic [9:0] MAX_FRACTION = 10'd999;

  localparam logic [26:0] MS_PER_HOUR   = 27'd3600000;
  localparam logic [21:0] MS_PER_MINUTE = 22'd60000;
  localparam logic [15:0] MS_PER_SECOND = 16'd1000;
  localparam logic [26:0] MS_DAY_MAX    = 27'd86399999;

  localparam int JOB_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

endpackage

// ===== src/tsmp_front.sv =====
// Character front end: grammar state machine and digit accumulation.
// Depends on tsmp_pkg; hands one job per string to the job queue.
module tsmp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsmp_pkg::item_t item,
  input  logic           job_full,
  output logic           job_push,
  output tsmp_pkg::job_t job
);
  import tsmp_pkg::*;

  typedef enum logic [1:0] {PH_BEFORE, PH_SIGN, PH_DIGITS, PH_AFTER} phase_t;

  localparam logic [1:0] F_HOURS    = 2'd0;
  localparam logic [1:0] F_MINUTES  = 2'd1;
  localparam logic [1:0] F_SECONDS  = 2'd2;
  localparam logic [1:0] F_FRACTION = 2'd3;

  phase_t     phase, phase_next;
  logic [1:0] field, field_next;
  logic       long_form, long_form_next;
  logic [1:0] pending, pending_next;
  logic       negative, negative_next;
  logic [6:0] hours_acc, hours_next;
  logic [6:0] minutes_acc, minutes_next;
  logic [6:0] seconds_acc, seconds_next;
  logic [9:0] fraction_acc, fraction_next;
  logic       failed, failed_next;

  logic       accept;
  logic [7:0] c;
  logic [3:0] dval;
  logic       is_ws, is_dig, is_sign;
  logic [9:0] cur_acc, acc_mul, acc_masked;
  logic [1:0] need, pending_inc;
  logic       do_begin, do_start;
  logic [1:0] bn_field;
  logic       acc_we;
  logic [1:0] acc_field;
  logic [9:0] acc_val;
  logic       good;

  assign accept = push && !job_full;
  assign c      = item.ch;
  assign dval   = c[3:0];
  assign is_ws  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_sign = (c == CH_PLUS) || (c == CH_MINUS);

  always_comb begin
    case (field)
      F_HOURS:   cur_acc = {3'd0, hours_acc};
      F_MINUTES: cur_acc = {3'd0, minutes_acc};
      F_SECONDS: cur_acc = {3'd0, seconds_acc};
      default:   cur_acc = fraction_acc;
    endcase
  end

  assign acc_mul     = {cur_acc[6:0], 3'b000} + {cur_acc[8:0], 1'b0} + {6'd0, dval};
  assign acc_masked  = (field == F_FRACTION) ? acc_mul : {3'd0, acc_mul[6:0]};
  assign need        = (field == F_FRACTION) ? 2'd3 : 2'd2;
  assign pending_inc = pending + 2'd1;

  always_comb begin
    phase_next     = phase;
    field_next     = field;
    long_form_next = long_form;
    pending_next   = pending;
    negative_next  = negative;
    failed_next    = failed;
    do_begin       = 1'b0;
    do_start       = 1'b0;
    bn_field       = field;
    acc_we         = 1'b0;
    acc_field      = field;
    acc_val        = acc_mul;

    if (!failed) begin
      case (phase)
        PH_BEFORE: begin
          if (!is_ws) begin
            do_begin = 1'b1;
          end
        end
        PH_SIGN: begin
          if (is_dig) begin
            do_start = 1'b1;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (!is_dig) begin
            failed_next = 1'b1;
          end else begin
            acc_we       = 1'b1;
            pending_next = pending_inc;
            if (pending_inc >= need) begin
              if (negative && acc_masked != 10'd0) begin
                failed_next = 1'b1;
              end else begin
                phase_next = PH_AFTER;
              end
            end
          end
        end
        default: begin
          if (!is_ws) begin
            if (field == F_HOURS) begin
              if (c == CH_COLON) begin
                long_form_next = 1'b1;
                field_next     = F_MINUTES;
                phase_next     = PH_BEFORE;
              end else begin
                long_form_next = 1'b0;
                do_begin       = 1'b1;
                bn_field       = F_MINUTES;
              end
            end else if (field == F_MINUTES) begin
              if (long_form) begin
                if (c == CH_COLON) begin
                  field_next = F_SECONDS;
                  phase_next = PH_BEFORE;
                end else begin
                  failed_next = 1'b1;
                end
              end else begin
                do_begin = 1'b1;
                bn_field = F_SECONDS;
              end
            end else if (field == F_SECONDS && long_form && c == CH_DOT) begin
              field_next = F_FRACTION;
              phase_next = PH_BEFORE;
            end else begin
              failed_next = 1'b1;
            end
          end
        end
      endcase
    end

    if (do_begin) begin
      negative_next = 1'b0;
      if (is_sign) begin
        negative_next = (c == CH_MINUS);
        field_next    = bn_field;
        phase_next    = PH_SIGN;
      end else if (is_dig) begin
        do_start = 1'b1;
      end else begin
        failed_next = 1'b1;
      end
    end

    if (do_start) begin
      acc_we       = 1'b1;
      acc_field    = bn_field;
      acc_val      = {6'd0, dval};
      pending_next = 2'd1;
      field_next   = bn_field;
      phase_next   = PH_DIGITS;
    end

    hours_next    = hours_acc;
    minutes_next  = minutes_acc;
    seconds_next  = seconds_acc;
    fraction_next = fraction_acc;
    if (acc_we) begin
      case (acc_field)
        F_HOURS:   hours_next    = acc_val[6:0];
        F_MINUTES: minutes_next  = acc_val[6:0];
        F_SECONDS: seconds_next  = acc_val[6:0];
        default:   fraction_next = acc_val;
      endcase
    end
  end

  always_comb begin
    good = !failed_next && phase_next == PH_AFTER &&
           field_next == (long_form_next ? F_FRACTION : F_SECONDS);
    if (hours_next > MAX_HOURS || minutes_next > MAX_MINSEC ||
        seconds_next > MAX_MINSEC || fraction_next > MAX_FRACTION) begin
      good = 1'b0;
    end
    job.ok         = good;
    job.hours      = hours_next[4:0];
    job.minutes    = minutes_next[5:0];
    job.seconds    = seconds_next[5:0];
    job.fraction   = long_form_next ? fraction_next : 10'd0;
    job.now_millis = item.now_millis;
    job.today      = item.today;
  end

  assign job_push = accept && item.last;

  always_ff @(posedge clk) begin
    if (rst || (accept && item.last)) begin
      phase        <= PH_BEFORE;
      field        <= F_HOURS;
      long_form    <= 1'b0;
      pending      <= 2'd0;
      negative     <= 1'b0;
      hours_acc    <= 7'd0;
      minutes_acc  <= 7'd0;
      seconds_acc  <= 7'd0;
      fraction_acc <= 10'd0;
      failed       <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      field        <= field_next;
      long_form    <= long_form_next;
      pending      <= pending_next;
      negative     <= negative_next;
      hours_acc    <= hours_next;
      minutes_acc  <= minutes_next;
      seconds_acc  <= seconds_next;
      fraction_acc <= fraction_next;
      failed       <= failed_next;
    end
  end

endmodule

// ===== src/tsmp_queue.sv =====
// Short job queue between the character front end and the arithmetic back end.
// Depends on tsmp_pkg for the job record and the queue depth.
module tsmp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tsmp_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output tsmp_pkg::job_t rd_job,
  output logic           empty
);
  import tsmp_pkg::*;

  localparam int AW = $clog2(JOB_DEPTH);

  job_t          slots [JOB_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == (AW+1)'(JOB_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// ===== src/tsmp_back.sv =====
// Arithmetic back end: millisecond sum, day rollback and the result queue.
// Depends on tsmp_pkg and assert_macros.svh; takes jobs from the job queue.
`include "assert_macros.svh"

module tsmp_back (
  input  logic              clk,
  input  logic              rst,
  input  tsmp_pkg::job_t    job,
  input  logic              job_empty,
  output logic              job_pop,
  output tsmp_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import tsmp_pkg::*;

  logic        v1, ok1;
  logic [26:0] ph1;
  logic [21:0] pm1;
  logic [15:0] ps1;
  logic [26:0] now1;
  logic [31:0] today1;

  logic        v2, ok2;
  logic [26:0] ms2, now2;
  logic [31:0] today2;

  result_t           fifo [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr, rd_ptr;
  logic [OUT_AW:0]   out_count;
  logic [OUT_AW:0]   pending_total;
  logic              pop_fire;
  result_t           wr_res;

  assign pending_total = out_count + (OUT_AW+1)'(v1) + (OUT_AW+1)'(v2);
  assign job_pop  = !job_empty && (pending_total < (OUT_AW+1)'(OUT_DEPTH));
  assign pop_fire = pop && (out_count != '0);
  assign empty    = (out_count == '0);
  assign result   = fifo[rd_ptr];

  always_comb begin
    wr_res.ok            = ok2;
    wr_res.millis_of_day = ok2 ? ms2 : 27'd0;
    wr_res.day_number    = 32'd0;
    if (ok2) begin
      wr_res.day_number = (ms2 >= now2) ? today2 - 32'd1 : today2;
    end
  end

  always_ff @(posedge clk) begin
    ok1    <= job.ok;
    ph1    <= {22'd0, job.hours} * MS_PER_HOUR;
    pm1    <= {16'd0, job.minutes} * MS_PER_MINUTE;
    ps1    <= {10'd0, job.seconds} * MS_PER_SECOND + {6'd0, job.fraction};
    now1   <= job.now_millis;
    today1 <= job.today;

    ok2    <= ok1;
    ms2    <= ph1 + {5'd0, pm1} + {11'd0, ps1};
    now2   <= now1;
    today2 <= today1;

    if (v2) begin
      fifo[wr_ptr] <= wr_res;
    end

    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      v1 <= job_pop;
      v2 <= v1;
      if (v2) begin
        wr_ptr <= wr_ptr + OUT_AW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + OUT_AW'(1);
      end
      out_count <= out_count + (OUT_AW+1)'(v2) - (OUT_AW+1)'(pop_fire);
    end
  end

  `TSMP_NEVER(a_no_overflow, v2 && !pop_fire && out_count == (OUT_AW+1)'(OUT_DEPTH), "result queue overflow")
  `TSMP_ASSERT(a_credit, (pending_total <= (OUT_AW+1)'(OUT_DEPTH)), "in-flight jobs exceed result space")
  `TSMP_ASSERT(a_ms_range, (v2 && ok2 |-> ms2 <= MS_DAY_MAX), "valid time beyond end of day")

endmodule

// ===== src/time_string_to_millis_parser.sv =====
// Timestamp string parser, top level: front end, job queue and back end.
// Depends on tsmp_pkg, tsmp_front, tsmp_queue and tsmp_back.
//
// The block takes one character per clock cycle while full is low, in either the
// "hhmmss" or the "hh:mm:ss.fff" form, and the character marked last closes the
// string. The front end steps its grammar state machine once per character, so
// characters stream in back to back while full is low. On the last character it
// hands a job to a two-entry queue; the back end forms the milliseconds in a
// two-stage multiply and add pipeline, and one string can finish in every cycle
// while the result queue has room. Full rises only when both job queue entries
// are waiting, which happens when the result queue has backed up.
module time_string_to_millis_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsmp_pkg::item_t   item,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output tsmp_pkg::result_t result
);
  import tsmp_pkg::*;

  job_t front_job, back_job;
  logic job_push, job_full, job_pop, job_empty;

  assign full = job_full;

  tsmp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .job_full (job_full),
    .job_push (job_push),
    .job      (front_job)
  );

  tsmp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (front_job),
    .full   (job_full),
    .pop    (job_pop),
    .rd_job (back_job),
    .empty  (job_empty)
  );

  tsmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== tb/tb_time_string_to_millis_parser.sv =====
// Self-checking testbench for the timestamp string parser, both forms and all error paths.
// Depends on tsmp_pkg and time_string_to_millis_parser; predicts each result itself or
// takes it from a typed table row, and checks each popped result against it.
module tb_time_string_to_millis_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import tsmp_pkg::*;

  localparam int unsigned TOTAL_CHARS = 2000;
  localparam int unsigned HOLD_AT     = 700;
  localparam int unsigned PAUSE_AT    = 1400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int NUM_ROWS = 27;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  localparam logic [7:0] PUNCT [5] = '{CH_COLON, CH_DOT, CH_PLUS, CH_MINUS, CH_SPACE};
  localparam result_t PARSE_ERR = '0;

  typedef enum logic [1:0] {PH_BEFORE, PH_SIGN, PH_DIGITS, PH_AFTER} phase_e;
  typedef enum logic [1:0] {FLD_HOURS, FLD_MINUTES, FLD_SECONDS, FLD_FRACTION} field_e;
  typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HALF, RX_SPARSE} rx_mode_e;

  typedef struct {
    string       text;
    logic [26:0] now;
    logic [31:0] today;
    bit          typed;
    result_t     want;
  } stamp_row_t;

  stamp_row_t stamp_rows [NUM_ROWS] = '{
    '{"000000", 27'd0, 32'd0, 1'b1, '{1'b1, 27'd0, 32'hFFFF_FFFF}},
    '{"23:59:59.999", 27'd86399999, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, 27'd86399999, 32'hFFFF_FFFE}},
    '{"235959", 27'h7FF_FFFF, 32'd1234, 1'b0, PARSE_ERR},
    '{" \t12:34:56.789 \r\n", 27'd45296789, 32'd100, 1'b0, PARSE_ERR},
    '{"\013\01407 : 08 : 09 . 010\013", 27'd0, 32'd5, 1'b0, PARSE_ERR},
    '{"-00-00+00", 27'd1, 32'd0, 1'b0, PARSE_ERR},
    '{"00:-00:+05.-000", 27'd5000, 32'd7, 1'b0, PARSE_ERR},
    '{"240000", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"006000", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"000060", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"23:59:60.000", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"-01 00 00", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"1234567", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"12:34", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"12:34:56", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"12:34:56.", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"1 23456", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"+ 123456", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"12:3456.000", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"123456.000", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{" ", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"\377\200", 27'h7FF_FFFF, 32'hFFFF_FFFF, 1'b1, PARSE_ERR},
    '{"12:34:56.7890", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"\01012:00:00.000", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"12\016000000", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"12/", 27'd0, 32'd9, 1'b1, PARSE_ERR},
    '{"12:34:56.999", 27'd0, 32'd0, 1'b0, PARSE_ERR}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  result_t     pending_stamps[$];
  int unsigned chars_sent = 0;
  int unsigned strings_done = 0;
  int unsigned stamps_checked = 0;
  int unsigned parse_errors = 0;
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  bit          sender_steady = 1'b0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_left = 0;
  rx_mode_e    rx_mode = RX_STEADY;
  int unsigned idle_cycles = 0;

  field_e     gp_field = FLD_HOURS;
  phase_e     gp_phase = PH_BEFORE;
  logic       gp_long = 1'b0;
  logic [3:0] gp_ndig = '0;
  logic       gp_neg = 1'b0;
  logic [6:0] gp_hours = '0;
  logic [6:0] gp_minutes = '0;
  logic [6:0] gp_seconds = '0;
  logic [9:0] gp_fraction = '0;
  logic       gp_failed = 1'b0;

  time_string_to_millis_parser uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit_ch(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int field_value(field_e f);
    case (f)
      FLD_HOURS:   return int'(gp_hours);
      FLD_MINUTES: return int'(gp_minutes);
      FLD_SECONDS: return int'(gp_seconds);
      default:     return int'(gp_fraction);
    endcase
  endfunction

  function automatic void load_field(field_e f, int v);
    case (f)
      FLD_HOURS:   gp_hours = 7'(v);
      FLD_MINUTES: gp_minutes = 7'(v);
      FLD_SECONDS: gp_seconds = 7'(v);
      default:     gp_fraction = 10'(v);
    endcase
  endfunction

  function automatic void clear_grammar();
    gp_field = FLD_HOURS;
    gp_phase = PH_BEFORE;
    gp_long = 1'b0;
    gp_ndig = '0;
    gp_neg = 1'b0;
    gp_hours = '0;
    gp_minutes = '0;
    gp_seconds = '0;
    gp_fraction = '0;
    gp_failed = 1'b0;
  endfunction

  function automatic void first_digit(field_e f, logic [7:0] c);
    load_field(f, int'(c - CH_ZERO));
    gp_ndig = 4'd1;
    gp_field = f;
    gp_phase = PH_DIGITS;
  endfunction

  function automatic void open_number(field_e f, logic [7:0] c);
    gp_neg = 1'b0;
    if (c == CH_PLUS || c == CH_MINUS) begin
      gp_neg = (c == CH_MINUS);
      gp_field = f;
      gp_phase = PH_SIGN;
    end else if (is_digit_ch(c)) begin
      first_digit(f, c);
    end else begin
      gp_failed = 1'b1;
    end
  endfunction

  function automatic void grammar_step(logic [7:0] c);
    if (gp_failed) return;
    case (gp_phase)
      PH_BEFORE: begin
        if (!is_blank(c)) open_number(gp_field, c);
      end
      PH_SIGN: begin
        if (is_digit_ch(c)) first_digit(gp_field, c);
        else gp_failed = 1'b1;
      end
      PH_DIGITS: begin
        if (!is_digit_ch(c)) begin
          gp_failed = 1'b1;
        end else begin
          load_field(gp_field, field_value(gp_field) * 10 + int'(c - CH_ZERO));
          gp_ndig = gp_ndig + 4'd1;
          if (gp_ndig >= ((gp_field == FLD_FRACTION) ? 4'd3 : 4'd2)) begin
            if (gp_neg && field_value(gp_field) != 0) gp_failed = 1'b1;
            else gp_phase = PH_AFTER;
          end
        end
      end
      default: begin
        if (!is_blank(c)) begin
          case (gp_field)
            FLD_HOURS: begin
              if (c == CH_COLON) begin
                gp_long = 1'b1;
                gp_field = FLD_MINUTES;
                gp_phase = PH_BEFORE;
              end else begin
                gp_long = 1'b0;
                open_number(FLD_MINUTES, c);
              end
            end
            FLD_MINUTES: begin
              if (!gp_long) begin
                open_number(FLD_SECONDS, c);
              end else if (c == CH_COLON) begin
                gp_field = FLD_SECONDS;
                gp_phase = PH_BEFORE;
              end else begin
                gp_failed = 1'b1;
              end
            end
            FLD_SECONDS: begin
              if (gp_long && c == CH_DOT) begin
                gp_field = FLD_FRACTION;
                gp_phase = PH_BEFORE;
              end else begin
                gp_failed = 1'b1;
              end
            end
            default: gp_failed = 1'b1;
          endcase
        end
      end
    endcase
  endfunction

  function automatic bit predict_stamp(item_t it, output result_t r);
    logic [31:0] ms;
    bit good;
    r = '0;
    grammar_step(it.ch);
    if (!it.last) return 1'b0;
    good = !gp_failed && gp_phase == PH_AFTER &&
           gp_field == (gp_long ? FLD_FRACTION : FLD_SECONDS) &&
           gp_hours <= MAX_HOURS && gp_minutes <= MAX_MINSEC &&
           gp_seconds <= MAX_MINSEC && gp_fraction <= MAX_FRACTION;
    if (good) begin
      ms = 32'(gp_hours) * 32'(MS_PER_HOUR) + 32'(gp_minutes) * 32'(MS_PER_MINUTE) +
           32'(gp_seconds) * 32'(MS_PER_SECOND) + (gp_long ? 32'(gp_fraction) : 32'd0);
      r.ok = 1'b1;
      r.millis_of_day = ms[26:0];
      r.day_number = (ms >= 32'(it.now_millis)) ? it.today - 32'd1 : it.today;
    end
    clear_grammar();
    return 1'b1;
  endfunction

  task automatic check_stamp(result_t got);
    result_t want;
    if (pending_stamps.size() == 0) begin
      $error("unexpected result: ok=%0b millis_of_day=%0d day_number=%0d",
             got.ok, got.millis_of_day, got.day_number);
      error_count++;
      return;
    end
    want = pending_stamps.pop_front();
    stamps_checked++;
    if (!want.ok) parse_errors++;
    if (got.ok !== want.ok) begin
      $error("ok: expected %0b, got %0b", want.ok, got.ok);
      error_count++;
    end
    if (got.millis_of_day !== want.millis_of_day) begin
      $error("millis_of_day: expected %0d, got %0d", want.millis_of_day, got.millis_of_day);
      error_count++;
    end
    if (got.day_number !== want.day_number) begin
      $error("day_number: expected %0d, got %0d", want.day_number, got.day_number);
      error_count++;
    end
  endtask

  task automatic send_char(item_t it, output bit got, output result_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    chars_sent++;
    got = predict_stamp(it, r);
  endtask

  task automatic send_stamp(logic [7:0] chars[$], logic [26:0] now_ms, logic [31:0] day,
                            bit typed, result_t want);
    item_t it;
    result_t r;
    bit got;
    for (int i = 0; i < chars.size(); i++) begin
      it.ch = chars[i];
      it.last = (i == chars.size() - 1);
      it.now_millis = it.last ? now_ms : 27'($urandom());
      it.today = it.last ? day : $urandom();
      send_char(it, got, r);
      if (got) begin
        pending_stamps.push_back(typed ? want : r);
        strings_done++;
      end
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending_stamps.size() != 0);
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return CH_ZERO + 8'($urandom_range(0, 9));
      2:       return PUNCT[$urandom_range(0, 4)];
      default: return BLANKS[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic void add_blanks(ref logic [7:0] q[$]);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) q.push_back(BLANKS[$urandom_range(0, 5)]);
    end
  endfunction

  function automatic int pick_value(int maxv);
    if ($urandom_range(0, 7) == 0) return $urandom_range(maxv + 1, 99);
    return $urandom_range(0, maxv);
  endfunction

  function automatic void add_number(ref logic [7:0] q[$], input int v, input int ndig);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      q.push_back(CH_PLUS);
    end else if (r == 1) begin
      q.push_back(CH_MINUS);
      if ($urandom_range(0, 3) != 0) v = 0;
    end
    if (ndig == 3) q.push_back(CH_ZERO + 8'(v / 100));
    q.push_back(CH_ZERO + 8'((v / 10) % 10));
    q.push_back(CH_ZERO + 8'(v % 10));
  endfunction

  function automatic void build_stamp(ref logic [7:0] q[$]);
    bit long_f;
    int pick;
    long_f = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 10)) q.push_back(noise_char());
      return;
    end
    add_blanks(q);
    add_number(q, pick_value(23), 2);
    add_blanks(q);
    if (long_f) begin
      q.push_back(CH_COLON);
      add_blanks(q);
    end
    add_number(q, pick_value(59), 2);
    add_blanks(q);
    if (long_f) begin
      q.push_back(CH_COLON);
      add_blanks(q);
    end
    add_number(q, pick_value(59), 2);
    if (long_f) begin
      add_blanks(q);
      q.push_back(CH_DOT);
      add_blanks(q);
      add_number(q, $urandom_range(0, 999), 3);
    end
    add_blanks(q);
    if (pick == 1) q[$urandom_range(0, q.size() - 1)] = noise_char();
    else if (pick == 2) q = q[0:$urandom_range(0, q.size() - 2)];
    else if (pick == 3) q.insert($urandom_range(0, q.size()), CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_stamp(result);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_left = $urandom_range(8, 60);
          rx_mode = rx_mode_e'($urandom_range(0, 3));
        end
        rx_left--;
        case (rx_mode)
          RX_STEADY: pop <= 1'b1;
          RX_LIGHT:  pop <= ($urandom_range(0, 3) != 0);
          RX_HALF:   pop <= 1'($urandom_range(0, 1));
          default:   pop <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] chars[$];
    logic [26:0] now_ms;
    int unsigned steady_left;
    bit hold_issued;
    bit pause_done;
    steady_left = 0;
    hold_issued = 1'b0;
    pause_done = 1'b0;
    clear_grammar();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (stamp_rows[i]) begin
      chars = {};
      for (int k = 0; k < stamp_rows[i].text.len(); k++) chars.push_back(stamp_rows[i].text[k]);
      send_stamp(chars, stamp_rows[i].now, stamp_rows[i].today, stamp_rows[i].typed,
                 stamp_rows[i].want);
    end
    drain_results();

    while (chars_sent < TOTAL_CHARS) begin
      if (!hold_issued && chars_sent >= HOLD_AT) begin
        hold_issued = 1'b1;
        hold_asks++;
        steady_left = 25;
      end
      if (!pause_done && chars_sent >= PAUSE_AT) begin
        pause_done = 1'b1;
        drain_results();
      end
      if (steady_left > 0) begin
        sender_steady = 1'b1;
        steady_left--;
      end else begin
        sender_steady = ($urandom_range(0, 4) == 0);
      end
      chars = {};
      build_stamp(chars);
      case ($urandom_range(0, 7))
        0:       now_ms = 27'($urandom());
        1:       now_ms = '0;
        default: now_ms = 27'($urandom_range(0, MS_DAY_MAX));
      endcase
      send_stamp(chars, now_ms, $urandom(), 1'b0, PARSE_ERR);
    end
    drain_results();
    repeat (12) @(posedge clk);

    $display("Sent %0d characters in %0d strings; checked %0d results, %0d of them errors.",
             chars_sent, strings_done, stamps_checked, parse_errors);
    $display("Both forms, signs, blanks, range limits, damaged strings, full stall, drain pause.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== time_string_to_millis_parser.f =====
+incdir+src
src/tsmp_pkg.sv
src/tsmp_front.sv
src/tsmp_queue.sv
src/tsmp_back.sv
src/time_string_to_millis_parser.sv
tb/tb_time_string_to_millis_parser.sv
